/* sv/sort_points_by_center_distance_defines.svh */
// ----------------------------------------------------------------------------
// Center-distance sort: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SORT_POINTS_BY_CENTER_DISTANCE_DEFINES_SVH
`define SORT_POINTS_BY_CENTER_DISTANCE_DEFINES_SVH

// Same-cycle implication
`define SPCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spcd same-cycle check failed");

// Next-cycle implication
`define SPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spcd next-cycle check failed");

`endif

/* sv/spcd_pkg.sv */
// ----------------------------------------------------------------------------
// Center-distance sort: package
// Sizes, point record and the command/status bundles between the units.
// ----------------------------------------------------------------------------
package spcd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int ID_W    = 20;
    localparam int LAT_W   = 30;
    localparam int LON_W   = 31;
    localparam int PT_W    = ID_W + LAT_W + LON_W;
    localparam int TDATA_W = ((PT_W + 7) / 8) * 8;

    localparam int DLAT_W = LAT_W + 1;
    localparam int DLON_W = LON_W + 1;
    localparam int DIST_W = 2 * DLON_W;

    // cycles from the last read issue until the best entry is settled
    localparam int DRAIN_CYC = 4;
    localparam int DRAIN_W   = $clog2(DRAIN_CYC);

    typedef struct packed {
        logic        [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
        logic        [ID_W-1:0]  id;
    } t_point;

    typedef struct packed {
        logic             load;
        logic             issue;
        logic [IDX_W-1:0] rd_addr;
        logic             emit;
        logic             emit_last;
        logic             clear_set;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             out_free;
    } t_sts;

endpackage

/* sv/spcd_ctrl.sv */
// ----------------------------------------------------------------------------
// Center-distance sort: controller
// Sequences load, repeated minimum scans and the emit of each result.
// ----------------------------------------------------------------------------
module spcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_s_tlast,
    output logic            o_s_tready,
    input  spcd_pkg::t_sts  i_sts,
    output spcd_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [spcd_pkg::CNT_W-1:0]    r_idx, n_idx;
    logic [spcd_pkg::CNT_W-1:0]    r_rank, n_rank;
    logic [spcd_pkg::DRAIN_W-1:0]  r_drain, n_drain;
    logic [spcd_pkg::CNT_W-1:0]    w_top;

    assign w_top = i_sts.count - spcd_pkg::CNT_W'(1);

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rank     = r_rank;
        n_drain    = r_drain;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_addr = r_idx[spcd_pkg::IDX_W-1:0];
        unique case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_ISSUE;
                    n_idx   = '0;
                    n_rank  = '0;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (r_idx == w_top) begin
                    n_state = S_DRAIN;
                    n_drain = '0;
                end else begin
                    n_idx = r_idx + spcd_pkg::CNT_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_drain == spcd_pkg::DRAIN_W'(spcd_pkg::DRAIN_CYC - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_drain = r_drain + spcd_pkg::DRAIN_W'(1);
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = (r_rank == w_top);
                    if (r_rank == w_top) begin
                        o_cmd.clear_set = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        n_rank  = r_rank + spcd_pkg::CNT_W'(1);
                        n_idx   = '0;
                        n_state = S_ISSUE;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_rank  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_rank  <= n_rank;
            r_drain <= n_drain;
        end
    end

endmodule

/* sv/spcd_dp.sv */
// ----------------------------------------------------------------------------
// Center-distance sort: datapath
// Point store, bounding box, distance pipeline, best tracking, output beat.
// ----------------------------------------------------------------------------
module spcd_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spcd_pkg::t_cmd       i_cmd,
    output spcd_pkg::t_sts       o_sts,
    input  spcd_pkg::t_point     i_point,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output spcd_pkg::t_point     o_m_point,
    output logic                 o_m_last,
    output logic                 o_m_ovf
);

    localparam int LAT_W  = spcd_pkg::LAT_W;
    localparam int LON_W  = spcd_pkg::LON_W;
    localparam int DLAT_W = spcd_pkg::DLAT_W;
    localparam int DLON_W = spcd_pkg::DLON_W;
    localparam int DIST_W = spcd_pkg::DIST_W;
    localparam int IDX_W  = spcd_pkg::IDX_W;
    localparam int CNT_W  = spcd_pkg::CNT_W;

    spcd_pkg::t_point r_mem [spcd_pkg::MAX_POINTS];

    logic [CNT_W-1:0]        r_count;
    logic                    r_dropped;
    logic signed [LAT_W-1:0] r_max_lat, r_min_lat;
    logic signed [LON_W-1:0] r_max_lon, r_min_lon;

    logic                    r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic [IDX_W-1:0]        r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx;
    spcd_pkg::t_point        r_s1_pt, r_s2_pt, r_s3_pt, r_s4_pt;
    logic signed [DLAT_W-1:0]   r_dlat;
    logic signed [DLON_W-1:0]   r_dlon;
    logic signed [2*DLAT_W-1:0] r_sqlat;
    logic signed [2*DLON_W-1:0] r_sqlon;
    logic [DIST_W-1:0]       r_s4_dist;
    logic                    r_s4_qual;

    logic                    r_have_best, r_have_prev;
    logic [DIST_W-1:0]       r_best_dist, r_prev_dist;
    logic [IDX_W-1:0]        r_best_idx, r_prev_idx;
    spcd_pkg::t_point        r_best_pt;

    logic                    r_ovld, r_olast, r_oovf;
    spcd_pkg::t_point        r_opt;

    logic signed [DLAT_W-1:0] w_clat;
    logic signed [DLON_W-1:0] w_clon;
    logic [DIST_W-1:0]        w_dist;
    logic                     w_room;

    assign w_room = (r_count < CNT_W'(spcd_pkg::MAX_POINTS));

    // box center, floor of the halved sum
    assign w_clat = $signed({r_max_lat[LAT_W-1], r_max_lat} +
                            {r_min_lat[LAT_W-1], r_min_lat}) >>> 1;
    assign w_clon = $signed({r_max_lon[LON_W-1], r_max_lon} +
                            {r_min_lon[LON_W-1], r_min_lon}) >>> 1;

    assign w_dist = {{(DIST_W-2*DLAT_W){1'b0}}, r_sqlat} + r_sqlon;

    // point store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            r_mem[r_count[IDX_W-1:0]] <= i_point;
        end
        r_s1_pt  <= r_mem[i_cmd.rd_addr];
        r_s1_idx <= i_cmd.rd_addr;
    end

    // set bookkeeping and box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.clear_set) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_room) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            if (r_count == '0) begin
                r_max_lat <= i_point.lat;
                r_min_lat <= i_point.lat;
                r_max_lon <= i_point.lon;
                r_min_lon <= i_point.lon;
            end else begin
                if (i_point.lat > r_max_lat) r_max_lat <= i_point.lat;
                if (i_point.lat < r_min_lat) r_min_lat <= i_point.lat;
                if ($signed(i_point.lon) > $signed(r_max_lon)) r_max_lon <= i_point.lon;
                if ($signed(i_point.lon) < $signed(r_min_lon)) r_min_lon <= i_point.lon;
            end
        end
    end

    // distance pipeline payload
    always_ff @(posedge i_clk) begin
        r_dlat    <= {i_dummy_lat_sext(r_s1_pt.lat)} - w_clat;
        r_dlon    <= {r_s1_pt.lon[LON_W-1], r_s1_pt.lon} - w_clon;
        r_s2_pt   <= r_s1_pt;
        r_s2_idx  <= r_s1_idx;
        r_sqlat   <= r_dlat * r_dlat;
        r_sqlon   <= r_dlon * r_dlon;
        r_s3_pt   <= r_s2_pt;
        r_s3_idx  <= r_s2_idx;
        r_s4_dist <= w_dist;
        r_s4_qual <= !r_have_prev || ({w_dist, r_s3_idx} > {r_prev_dist, r_prev_idx});
        r_s4_pt   <= r_s3_pt;
        r_s4_idx  <= r_s3_idx;
    end

    function automatic logic signed [DLAT_W-1:0] i_dummy_lat_sext(
        input logic signed [LAT_W-1:0] v
    );
        i_dummy_lat_sext = {v[LAT_W-1], v};
    endfunction

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    // track the smallest key above the previous emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
        end else if (i_cmd.emit) begin
            r_have_best <= 1'b0;
        end else if (r_s4_vld && r_s4_qual &&
                     (!r_have_best || ({r_s4_dist, r_s4_idx} < {r_best_dist, r_best_idx}))) begin
            r_have_best <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_cmd.emit && r_s4_vld && r_s4_qual &&
            (!r_have_best || ({r_s4_dist, r_s4_idx} < {r_best_dist, r_best_idx}))) begin
            r_best_dist <= r_s4_dist;
            r_best_idx  <= r_s4_idx;
            r_best_pt   <= r_s4_pt;
        end
        if (i_cmd.emit) begin
            r_prev_dist <= r_best_dist;
            r_prev_idx  <= r_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (i_cmd.clear_set) begin
            r_have_prev <= 1'b0;
        end else if (i_cmd.emit) begin
            r_have_prev <= 1'b1;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovld <= 1'b1;
        end else if (i_m_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_opt   <= r_best_pt;
            r_olast <= i_cmd.emit_last;
            r_oovf  <= r_dropped;
        end
    end

    assign o_sts.count    = r_count;
    assign o_sts.out_free = !r_ovld || i_m_tready;
    assign o_m_tvalid     = r_ovld;
    assign o_m_point      = r_opt;
    assign o_m_last       = r_olast;
    assign o_m_ovf        = r_oovf;

endmodule

/* sv/sort_points_by_center_distance.sv */
// ----------------------------------------------------------------------------
// Center-distance sort: top level
// Collects points, then emits them nearest to the bounding-box center first.
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | tdata: point_id[19:0], lat_in[49:20], lon_in[80:50]; tlast: last_in
// m_axis  | out | tdata: out_id[19:0], out_lat[49:20], out_lon[80:50];
//         |     | tlast: out_last; tuser: overflow
//
// Points load one per cycle. The beat with tlast starts the emit; each result
// takes a full scan of the n stored points through the distance pipeline.
// The single read port of the point store sets the scan length.
// No input beat is taken during the emit. Reset is synchronous, active low.
// A stalled output beat holds the scan at its emit step.
`include "sort_points_by_center_distance_defines.svh"

module sort_points_by_center_distance (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [spcd_pkg::TDATA_W-1:0] i_s_axis_tdata,  // point_id, lat_in, lon_in, pad
    input  logic                         i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [spcd_pkg::TDATA_W-1:0] o_m_axis_tdata,  // out_id, out_lat, out_lon, pad
    output logic                         o_m_axis_tlast,
    output logic                         o_m_axis_tuser   // overflow
);

    spcd_pkg::t_cmd   w_cmd;
    spcd_pkg::t_sts   w_sts;
    spcd_pkg::t_point w_in_pt;
    spcd_pkg::t_point w_out_pt;

    assign w_in_pt = i_s_axis_tdata[spcd_pkg::PT_W-1:0];
    assign o_m_axis_tdata = {{(spcd_pkg::TDATA_W-spcd_pkg::PT_W){1'b0}}, w_out_pt};

    spcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tlast  (i_s_axis_tlast),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    spcd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_point    (w_in_pt),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_point  (w_out_pt),
        .o_m_last   (o_m_axis_tlast),
        .o_m_ovf    (o_m_axis_tuser)
    );

    // no input beat taken while the store is being scanned
    `SPCD_ASSERT_NOW(a_no_load_in_scan, i_clk, i_rst_n, w_cmd.issue, !o_s_axis_tready)
    // an emit never overwrites a waiting result
    `SPCD_ASSERT_NOW(a_emit_when_free, i_clk, i_rst_n, w_cmd.emit, w_sts.out_free)
    // an emit presents a beat next cycle
    `SPCD_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, w_cmd.emit, o_m_axis_tvalid)

endmodule

/* test/sort_points_by_center_distance_tb.sv */
// ----------------------------------------------------------------------------
// Center-distance sort: testbench
// Streams point sets into the block and checks every emitted beat against a
// behavioural predictor of the bounding-box center and the stable sort.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sort_points_by_center_distance_tb;

    localparam int ID_W       = spcd_pkg::ID_W;
    localparam int LAT_W      = spcd_pkg::LAT_W;
    localparam int LON_W      = spcd_pkg::LON_W;
    localparam int PT_W       = spcd_pkg::PT_W;
    localparam int TDATA_W    = spcd_pkg::TDATA_W;
    localparam int MAX_POINTS = spcd_pkg::MAX_POINTS;

    typedef struct {
        logic [ID_W-1:0]         id;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        logic                    last;
        logic                    ovf;
    } t_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [TDATA_W-1:0]   i_s_axis_tdata;
    logic                 i_s_axis_tlast;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [TDATA_W-1:0]   o_m_axis_tdata;
    logic                 o_m_axis_tlast;
    logic                 o_m_axis_tuser;

    t_beat       pending_points[$];
    t_beat       sorted_points[$];
    logic [ID_W-1:0]         held_id[MAX_POINTS];
    logic signed [LAT_W-1:0] held_lat[MAX_POINTS];
    logic signed [LON_W-1:0] held_lon[MAX_POINTS];
    int          held_count;
    logic signed [LAT_W-1:0] lat_hi, lat_lo;
    logic signed [LON_W-1:0] lon_hi, lon_lo;
    logic        points_dropped;
    int          fail_count;
    int          beats_seen;
    int          sets_seen;
    int          stall_tx, stall_rx;
    int          idle_cycles;
    bit          calm;
    bit          stim_done;

    sort_points_by_center_distance u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // take one accepted point into the predictor, emit expectations on last
    task automatic predict_point(input t_beat p);
        longint signed clat, clon, dl, dn;
        longint unsigned sq_dist[MAX_POINTS];
        int          order[MAX_POINTS];
        int          key, j;
        t_beat       r;
        if (held_count < MAX_POINTS) begin
            held_id[held_count]  = p.id;
            held_lat[held_count] = p.lat;
            held_lon[held_count] = p.lon;
            if (held_count == 0) begin
                lat_hi = p.lat; lat_lo = p.lat; lon_hi = p.lon; lon_lo = p.lon;
            end else begin
                if (p.lat > lat_hi) lat_hi = p.lat;
                if (p.lat < lat_lo) lat_lo = p.lat;
                if (p.lon > lon_hi) lon_hi = p.lon;
                if (p.lon < lon_lo) lon_lo = p.lon;
            end
            held_count++;
        end else begin
            points_dropped = 1'b1;
        end
        if (!p.last) return;
        // arithmetic shift gives the floor of the half sum
        clat = (longint'(lat_hi) + longint'(lat_lo)) >>> 1;
        clon = (longint'(lon_hi) + longint'(lon_lo)) >>> 1;
        for (int i = 0; i < held_count; i++) begin
            dl = longint'(held_lat[i]) - clat;
            dn = longint'(held_lon[i]) - clon;
            sq_dist[i] = longint'(dl * dl) + longint'(dn * dn);
            order[i]   = i;
        end
        for (int i = 1; i < held_count; i++) begin
            key = order[i];
            j = i;
            while (j > 0 && sq_dist[order[j-1]] > sq_dist[key]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
        for (int i = 0; i < held_count; i++) begin
            r.id   = held_id[order[i]];
            r.lat  = held_lat[order[i]];
            r.lon  = held_lon[order[i]];
            r.last = (i == held_count - 1);
            r.ovf  = points_dropped;
            sorted_points = {sorted_points, r};
        end
        held_count = 0;
        points_dropped = 1'b0;
    endtask

    function automatic t_beat rand_point(input int mode);
        t_beat p;
        p.id = ID_W'($urandom);
        case (mode)
            0: begin
                p.lat = LAT_W'($urandom_range(0, 2 * 377487360) - 377487360);
                p.lon = LON_W'($urandom_range(0, 2 * 754974720) - 754974720);
            end
            1: begin
                // tight cluster to provoke ties
                p.lat = LAT_W'($urandom_range(0, 6) - 3);
                p.lon = LON_W'($urandom_range(0, 6) - 3);
            end
            default: begin
                // full two's complement range of each field
                p.lat = LAT_W'($urandom);
                p.lon = LON_W'($urandom);
            end
        endcase
        p.last = 1'b0;
        return p;
    endfunction

    task automatic add_set(input int n, input int mode);
        t_beat p;
        for (int i = 0; i < n; i++) begin
            p = rand_point(mode);
            p.last = (i == n - 1);
            pending_points = {pending_points, p};
        end
    endtask

    // stimulus
    initial begin
        t_beat p;
        int    n, total;
        // single point at the field extremes
        p.id = '1; p.lat = 30'sh1FFF_FFFF; p.lon = 31'sh3FFF_FFFF; p.last = 1'b1;
        pending_points = {pending_points, p};
        p.id = '0; p.lat = 30'sh2000_0000; p.lon = 31'sh4000_0000; p.last = 1'b0;
        pending_points = {pending_points, p};
        p.id = 20'h5A5A5; p.lat = 30'sh1FFF_FFFF; p.lon = 31'sh3FFF_FFFF; p.last = 1'b0;
        pending_points = {pending_points, p};
        p.id = 20'hA5A5A; p.lat = LAT_W'(377487360); p.lon = LON_W'(-754974720);
        p.last = 1'b0;
        pending_points = {pending_points, p};
        p.id = ID_W'(3); p.lat = LAT_W'(-377487360); p.lon = LON_W'(754974720);
        p.last = 1'b1;
        pending_points = {pending_points, p};
        // equal distances keep arrival order
        for (int i = 0; i < 4; i++) begin
            p.id = ID_W'(100 + i);
            p.lat = LAT_W'((i[0]) ? 10 : -10);
            p.lon = LON_W'((i[1]) ? 10 : -10);
            p.last = (i == 3);
            pending_points = {pending_points, p};
        end
        // overfilled store: the last point itself is dropped
        add_set(MAX_POINTS + 3, 1);
        total = pending_points.size();
        while (total < 480) begin
            case ($urandom_range(0, 9))
                0:       n = MAX_POINTS + $urandom_range(1, 4);
                1:       n = MAX_POINTS;
                default: n = $urandom_range(1, 12);
            endcase
            add_set(n, $urandom_range(0, 2));
            total += n;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            stall_tx        <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) predict_point(pending_points.pop_front());
            if (pending_points.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
                stim_done       <= 1'b1;
            end else if (stall_tx > 0) begin
                stall_tx        <= stall_tx - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_tx        <= $urandom_range(0, 10);
                i_s_axis_tvalid <= 1'b0;
            end else begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {{(TDATA_W - PT_W){1'b0}}, pending_points[0].lon,
                                    pending_points[0].lat, pending_points[0].id};
                i_s_axis_tlast  <= pending_points[0].last;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_rx        <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                beats_seen++;
                if (sorted_points.size() == 0) begin
                    $error("unexpected result beat id=%0h", o_m_axis_tdata[ID_W-1:0]);
                    fail_count++;
                end else begin
                    want = sorted_points.pop_front();
                    if (want.last) sets_seen++;
                    if (o_m_axis_tdata[ID_W-1:0] !== want.id) begin
                        $error("out_id exp %0h got %0h", want.id, o_m_axis_tdata[ID_W-1:0]);
                        fail_count++;
                    end
                    if (o_m_axis_tdata[ID_W +: LAT_W] !== want.lat) begin
                        $error("out_lat exp %0d got %0d", want.lat,
                               $signed(o_m_axis_tdata[ID_W +: LAT_W]));
                        fail_count++;
                    end
                    if (o_m_axis_tdata[ID_W+LAT_W +: LON_W] !== want.lon) begin
                        $error("out_lon exp %0d got %0d", want.lon,
                               $signed(o_m_axis_tdata[ID_W+LAT_W +: LON_W]));
                        fail_count++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("out_last exp %0b got %0b", want.last, o_m_axis_tlast);
                        fail_count++;
                    end
                    if (o_m_axis_tuser !== want.ovf) begin
                        $error("overflow exp %0b got %0b", want.ovf, o_m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if (stall_rx > 0) begin
                stall_rx        <= stall_rx - 1;
                i_m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_rx        <= $urandom_range(0, 10);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: a full set costs one store scan per result plus receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 40000) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 1'b0;
        i_m_axis_tready = 1'b0;
        held_count = 0;
        points_dropped = 1'b0;
        fail_count = 0;
        beats_seen = 0;
        sets_seen = 0;
        calm = 1'b0;
        stim_done = 1'b0;
        idle_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // drop idling once the stimulus is nearly used up
        wait (pending_points.size() < 40);
        @(posedge i_clk);
        calm <= 1'b1;
        wait (stim_done && sorted_points.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("covered %0d sets, %0d sorted beats checked", sets_seen, beats_seen);
        if (fail_count == 0 && sorted_points.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
